// File: rtl/core/thpc_pkg.sv
// Shared types and constants for the transport packet header checker.
`default_nettype none

package thpc_pkg;

  // Byte count saturates here
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // Fixed header layout
  localparam logic [7:0]  START_BYTE   = 8'h7E;
  localparam logic [7:0]  VERSION_BYTE = 8'h01;
  localparam logic [16:0] MIN_PKT_LEN  = 17'd12;
  localparam logic [7:0]  BASE_HDR_LEN = 8'd12;

  // Positions in the packed flag vector
  localparam int FLAG_CNT  = 0;
  localparam int FLAG_SKIP = 1;
  localparam int FLAG_CID  = 2;
  localparam int FLAG_DID  = 3;
  localparam int FLAG_SEG  = 4;

  // Status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_SHORT      = 4'd1;
  localparam logic [3:0] ST_START      = 4'd2;
  localparam logic [3:0] ST_VERSION    = 4'd3;
  localparam logic [3:0] ST_HDR_LEN    = 4'd4;
  localparam logic [3:0] ST_PKT_LEN    = 4'd5;
  localparam logic [3:0] ST_CRC        = 4'd6;
  localparam logic [3:0] ST_SEG_NO_ID  = 4'd7;
  localparam logic [3:0] ST_SEG_NO_CNT = 4'd8;

  // Header tracking state, as seen after the current byte
  typedef struct packed {
    logic [16:0] count;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic        start_ok;
    logic        ver_ok;
    logic [7:0]  hdr_len;
    logic [4:0]  flags;
    logic [15:0] counter;
    logic [31:0] client;
    logic [15:0] data_id;
    logic [15:0] seg;
    logic [7:0]  proto;
    logic [15:0] length;
  } hdr_t;

endpackage

`default_nettype wire

// File: rtl/core/thpc_hdr_state.sv
// Per-packet header state: byte count, field capture and header CRC.
`default_nettype none

module thpc_hdr_state import thpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output hdr_t            upd
);

  hdr_t cur;
  hdr_t blank;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [16:0] idx;
  logic [16:0] pos;
  logic [17:0] idx_p1;
  logic [17:0] idx_p2;
  logic [3:0]  beg_cid;
  logic [3:0]  beg_did;
  logic [3:0]  beg_seg;
  logic        opt_zone;
  logic        in_cnt;
  logic        in_cid;
  logic        in_did;
  logic        in_seg;

  assign idx    = cur.count;
  assign idx_p1 = {1'b0, idx} + 18'd1;
  assign idx_p2 = {1'b0, idx} + 18'd2;
  assign pos    = idx - 17'd10;

  // Optional field regions, laid out in flag order after byte 9
  assign beg_cid  = cur.flags[FLAG_CNT] ? 4'd2 : 4'd0;
  assign beg_did  = beg_cid + (cur.flags[FLAG_CID] ? 4'd4 : 4'd0);
  assign beg_seg  = beg_did + (cur.flags[FLAG_DID] ? 4'd2 : 4'd0);
  assign opt_zone = (idx >= 17'd10);
  assign in_cnt   = opt_zone && cur.flags[FLAG_CNT] && (pos < 17'd2);
  assign in_cid   = opt_zone && cur.flags[FLAG_CID] && (pos >= {13'd0, beg_cid}) &&
                    (pos < {13'd0, beg_cid} + 17'd4);
  assign in_did   = opt_zone && cur.flags[FLAG_DID] && (pos >= {13'd0, beg_did}) &&
                    (pos < {13'd0, beg_did} + 17'd2);
  assign in_seg   = opt_zone && cur.flags[FLAG_SEG] && (pos >= {13'd0, beg_seg}) &&
                    (pos < {13'd0, beg_seg} + 17'd2);

  // State after taking the current byte
  always_comb begin
    upd = cur;
    upd.count = (idx == COUNT_MAX) ? idx : idx_p1[16:0];
    case (idx)
      17'd0: if (data_byte == START_BYTE) upd.start_ok = 1'b1;
      17'd1: if (data_byte == VERSION_BYTE) upd.ver_ok = 1'b1;
      17'd2: upd.hdr_len = data_byte;
      17'd3: upd.length[15:8] = data_byte;
      17'd4: upd.length[7:0] = data_byte;
      17'd5: upd.proto = data_byte;
      17'd9: upd.flags = {data_byte[6], data_byte[5], data_byte[3], data_byte[2],
                          data_byte[0]};
      default: begin
        if (in_cnt) upd.counter = {cur.counter[7:0], data_byte};
        if (in_cid) upd.client  = {cur.client[23:0], data_byte};
        if (in_did) upd.data_id = {cur.data_id[7:0], data_byte};
        if (in_seg) upd.seg     = {cur.seg[7:0], data_byte};
      end
    endcase
    // CRC covers the header up to its own two bytes
    if (idx < 17'd3 || idx_p2 < {10'd0, cur.hdr_len}) begin
      upd.crc = crc16_byte(cur.crc, data_byte);
    end
    if (idx >= 17'd3 && idx_p2 == {10'd0, cur.hdr_len}) upd.rx_crc[15:8] = data_byte;
    if (idx >= 17'd3 && idx_p1 == {10'd0, cur.hdr_len}) upd.rx_crc[7:0] = data_byte;
  end

  // Empty packet state: all zero, CRC preset
  always_comb begin
    blank     = '0;
    blank.crc = 16'hFFFF;
  end

  // Advance per transaction, clear on reset or after the final byte
  always_ff @(posedge clk) begin
    if (rst || (go && last_byte)) begin
      cur <= blank;
    end else if (go) begin
      cur <= upd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/thpc_result.sv
// Packet checks in priority order and the registered result.
`default_nettype none

module thpc_result import thpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire hdr_t        hdr,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [3:0]       status,
  output logic [7:0]       app_protocol,
  output logic [15:0]      body_length,
  output logic             skip_payload_crc,
  output logic             has_counter,
  output logic [15:0]      message_counter,
  output logic             has_client_id,
  output logic [31:0]      client_id,
  output logic             has_data_id,
  output logic [15:0]      data_id,
  output logic             has_segmentation,
  output logic [15:0]      segment_count
);

  logic        fc, fs, fi, fd, fg;
  logic [7:0]  exp_hdr_len;
  logic [16:0] need;
  logic [3:0]  st;
  logic        ok;

  assign fc = hdr.flags[FLAG_CNT];
  assign fs = hdr.flags[FLAG_SKIP];
  assign fi = hdr.flags[FLAG_CID];
  assign fd = hdr.flags[FLAG_DID];
  assign fg = hdr.flags[FLAG_SEG];

  assign exp_hdr_len = BASE_HDR_LEN + (fc ? 8'd2 : 8'd0) + (fi ? 8'd4 : 8'd0) +
                       (fd ? 8'd2 : 8'd0) + (fg ? 8'd2 : 8'd0);
  assign need = {9'd0, hdr.hdr_len} + {1'b0, hdr.length} + (fs ? 17'd0 : 17'd2);

  // First failing check sets the status
  always_comb begin
    if (hdr.count < MIN_PKT_LEN)        st = ST_SHORT;
    else if (!hdr.start_ok)             st = ST_START;
    else if (!hdr.ver_ok)               st = ST_VERSION;
    else if (hdr.hdr_len != exp_hdr_len) st = ST_HDR_LEN;
    else if (hdr.count != need)         st = ST_PKT_LEN;
    else if (hdr.rx_crc != hdr.crc)     st = ST_CRC;
    else if (fg && !fd)                 st = ST_SEG_NO_ID;
    else if (fg && !fc)                 st = ST_SEG_NO_CNT;
    else                                st = ST_OK;
  end

  assign ok = (st == ST_OK);

  // Output valid: set on load, dropped once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; fields are zero on a failed packet
  always_ff @(posedge clk) begin
    if (load) begin
      status           <= st;
      app_protocol     <= ok ? hdr.proto : 8'd0;
      body_length      <= ok ? hdr.length : 16'd0;
      skip_payload_crc <= ok && fs;
      has_counter      <= ok && fc;
      message_counter  <= (ok && fc) ? hdr.counter : 16'd0;
      has_client_id    <= ok && fi;
      client_id        <= (ok && fi) ? hdr.client : 32'd0;
      has_data_id      <= ok && fd;
      data_id          <= (ok && fd) ? hdr.data_id : 16'd0;
      has_segmentation <= ok && fg;
      segment_count    <= (ok && fg) ? hdr.seg : 16'd0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/transport_packet_header_checker.sv
// Top level of the transport packet header checker.
//
//   channel | direction | payload                                   | handshake
//   in      | input     | data_byte, last_byte                      | in_valid / in_stall
//   out     | output    | status and decoded header fields (1/pkt)  | out_valid / out_stall
//
// One byte per cycle, unless a final byte waits on a held result; a result becomes
// valid once the final byte has passed the input register, then the header state
// update and checks into the result register. The per-byte CRC and field capture set the cycle's logic depth.
// Reset (rst, synchronous) empties both registers and clears the packet state.
// A stalled result holds only a final byte in the input register; ordinary bytes
// keep flowing while a result waits.
`default_nettype none

module transport_packet_header_checker import thpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic [7:0]       app_protocol,
  output logic [15:0]      body_length,
  output logic             skip_payload_crc,
  output logic             has_counter,
  output logic [15:0]      message_counter,
  output logic             has_client_id,
  output logic [31:0]      client_id,
  output logic             has_data_id,
  output logic [15:0]      data_id,
  output logic             has_segmentation,
  output logic [15:0]      segment_count
);

  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       s1_go;
  hdr_t       upd;

  // Input byte moves on unless it closes a packet and the result slot is held
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
  end

  thpc_hdr_state u_hdr (
    .clk       (clk),
    .rst       (rst),
    .go        (s1_go),
    .data_byte (s1_data),
    .last_byte (s1_last),
    .upd       (upd)
  );

  thpc_result u_res (
    .clk              (clk),
    .rst              (rst),
    .load             (s1_go && s1_last),
    .hdr              (upd),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .status           (status),
    .app_protocol     (app_protocol),
    .body_length      (body_length),
    .skip_payload_crc (skip_payload_crc),
    .has_counter      (has_counter),
    .message_counter  (message_counter),
    .has_client_id    (has_client_id),
    .client_id        (client_id),
    .has_data_id      (has_data_id),
    .data_id          (data_id),
    .has_segmentation (has_segmentation),
    .segment_count    (segment_count)
  );

endmodule

`default_nettype wire

// File: tb/transport_packet_header_checker_tb.sv
// Self-checking testbench for the transport packet header checker: byte driver, result monitor.
`timescale 1ns / 1ps

module transport_packet_header_checker_tb import thpc_pkg::*; ();

  // One byte on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packet_byte_t;

  // One decoded header report on the output channel
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  proto;
    logic [15:0] plen;
    logic        skip;
    logic        has_cnt;
    logic [15:0] cnt;
    logic        has_cid;
    logic [31:0] cid;
    logic        has_did;
    logic [15:0] did;
    logic        has_seg;
    logic [15:0] seg;
  } header_report_t;

  // Ways a generated frame gets damaged
  typedef enum int {
    DAMAGE_NONE,
    DAMAGE_SHORT,
    DAMAGE_START,
    DAMAGE_VERSION,
    DAMAGE_HDR_LEN,
    DAMAGE_PKT_LEN,
    DAMAGE_CRC,
    DAMAGE_FLIP
  } damage_t;

  localparam int STEADY_FROM = 400;
  localparam int STEADY_TO   = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  status;
  logic [7:0]  app_protocol;
  logic [15:0] body_length;
  logic        skip_payload_crc;
  logic        has_counter;
  logic [15:0] message_counter;
  logic        has_client_id;
  logic [31:0] client_id;
  logic        has_data_id;
  logic [15:0] data_id;
  logic        has_segmentation;
  logic [15:0] segment_count;

  packet_byte_t   pending_bytes[$];
  header_report_t expected_reports[$];
  logic [7:0]     frame[$];
  int             bytes_taken = 0;
  int             mismatches = 0;
  logic           steady_phase;

  // Header tracking state of the predictor
  int          byte_pos;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;
  logic        start_seen;
  logic        ver_seen;
  logic [7:0]  hdr_len_seen;
  logic [4:0]  flag_set;
  logic [15:0] cnt_val;
  logic [31:0] cid_val;
  logic [15:0] did_val;
  logic [15:0] seg_val;
  logic [7:0]  proto_val;
  logic [15:0] len_val;

  transport_packet_header_checker dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .app_protocol     (app_protocol),
    .body_length      (body_length),
    .skip_payload_crc (skip_payload_crc),
    .has_counter      (has_counter),
    .message_counter  (message_counter),
    .has_client_id    (has_client_id),
    .client_id        (client_id),
    .has_data_id      (has_data_id),
    .data_id          (data_id),
    .has_segmentation (has_segmentation),
    .segment_count    (segment_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // No idling on either side during one stretch of the byte stream
  assign steady_phase = (bytes_taken >= STEADY_FROM) && (bytes_taken < STEADY_TO);

  // CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_tracker();
    byte_pos     = 0;
    crc_acc      = 16'hFFFF;
    crc_rx       = 16'h0000;
    start_seen   = 1'b0;
    ver_seen     = 1'b0;
    hdr_len_seen = 8'h00;
    flag_set     = 5'b0;
    cnt_val      = 16'h0000;
    cid_val      = 32'h0;
    did_val      = 16'h0000;
    seg_val      = 16'h0000;
    proto_val    = 8'h00;
    len_val      = 16'h0000;
  endtask

  // Advance the header state by one accepted byte; queue a report on the final byte
  task automatic track_byte(input logic [7:0] b, input logic fin);
    int             i;
    int             hl;
    int             pos;
    int             flen;
    int             need;
    bit             taken;
    header_report_t rep;
    i  = byte_pos;
    hl = hdr_len_seen;
    if (i == 0) begin
      if (b == START_BYTE) start_seen = 1'b1;
    end else if (i == 1) begin
      if (b == VERSION_BYTE) ver_seen = 1'b1;
    end else if (i == 2) begin
      hdr_len_seen = b;
      hl = b;
    end else if (i == 3) begin
      len_val[15:8] = b;
    end else if (i == 4) begin
      len_val[7:0] = b;
    end else if (i == 5) begin
      proto_val = b;
    end else if (i == 9) begin
      flag_set = {b[6], b[5], b[3], b[2], b[0]};
    end else if (i >= 10) begin
      // optional fields in order: counter, client id, data id, segmentation
      pos   = i - 10;
      taken = 1'b0;
      if (flag_set[FLAG_CNT]) begin
        if (pos < 2) begin
          cnt_val = {cnt_val[7:0], b};
          taken = 1'b1;
        end else pos -= 2;
      end
      if (!taken && flag_set[FLAG_CID]) begin
        if (pos < 4) begin
          cid_val = {cid_val[23:0], b};
          taken = 1'b1;
        end else pos -= 4;
      end
      if (!taken && flag_set[FLAG_DID]) begin
        if (pos < 2) begin
          did_val = {did_val[7:0], b};
          taken = 1'b1;
        end else pos -= 2;
      end
      if (!taken && flag_set[FLAG_SEG] && pos < 2) seg_val = {seg_val[7:0], b};
    end

    // CRC covers bytes 0..2 and the header up to its CRC field
    if (i < 3 || i + 2 < hl) crc_acc = crc16_step(crc_acc, b);
    if (i >= 3 && i + 2 == hl) crc_rx[15:8] = b;
    if (i >= 3 && i + 1 == hl) crc_rx[7:0] = b;

    if (byte_pos < int'(COUNT_MAX)) byte_pos++;
    if (!fin) return;

    flen = 2 * flag_set[FLAG_CNT] + 4 * flag_set[FLAG_CID] + 2 * flag_set[FLAG_DID]
         + 2 * flag_set[FLAG_SEG];
    need = int'(hdr_len_seen) + int'(len_val) + (flag_set[FLAG_SKIP] ? 0 : 2);
    rep  = '0;
    if (byte_pos < int'(MIN_PKT_LEN)) rep.status = ST_SHORT;
    else if (!start_seen) rep.status = ST_START;
    else if (!ver_seen) rep.status = ST_VERSION;
    else if (int'(hdr_len_seen) != int'(BASE_HDR_LEN) + flen) rep.status = ST_HDR_LEN;
    else if (byte_pos != need) rep.status = ST_PKT_LEN;
    else if (crc_rx != crc_acc) rep.status = ST_CRC;
    else if (flag_set[FLAG_SEG] && !flag_set[FLAG_DID]) rep.status = ST_SEG_NO_ID;
    else if (flag_set[FLAG_SEG] && !flag_set[FLAG_CNT]) rep.status = ST_SEG_NO_CNT;
    else rep.status = ST_OK;

    // fields are reported only for a good packet
    if (rep.status == ST_OK) begin
      rep.proto   = proto_val;
      rep.plen    = len_val;
      rep.skip    = flag_set[FLAG_SKIP];
      rep.has_cnt = flag_set[FLAG_CNT];
      rep.cnt     = flag_set[FLAG_CNT] ? cnt_val : 16'h0;
      rep.has_cid = flag_set[FLAG_CID];
      rep.cid     = flag_set[FLAG_CID] ? cid_val : 32'h0;
      rep.has_did = flag_set[FLAG_DID];
      rep.did     = flag_set[FLAG_DID] ? did_val : 16'h0;
      rep.has_seg = flag_set[FLAG_SEG];
      rep.seg     = flag_set[FLAG_SEG] ? seg_val : 16'h0;
    end
    expected_reports.insert(expected_reports.size(), rep);
    clear_tracker();
  endtask

  // Well-formed frame: fixed header, optional fields, header CRC, payload, optional payload CRC
  task automatic build_frame(input logic [7:0] flags, input logic [7:0] proto,
                             input logic [15:0] plen, input logic [15:0] cnt,
                             input logic [31:0] cid, input logic [15:0] did,
                             input logic [15:0] seg);
    logic [7:0]  hl;
    logic [15:0] crc;
    hl = BASE_HDR_LEN + (flags[0] ? 8'd2 : 8'd0) + (flags[3] ? 8'd4 : 8'd0)
       + (flags[5] ? 8'd2 : 8'd0) + (flags[6] ? 8'd2 : 8'd0);
    frame.delete();
    frame.insert(frame.size(), START_BYTE);
    frame.insert(frame.size(), VERSION_BYTE);
    frame.insert(frame.size(), hl);
    frame.insert(frame.size(), plen[15:8]);
    frame.insert(frame.size(), plen[7:0]);
    frame.insert(frame.size(), proto);
    for (int k = 0; k < 3; k++) frame.insert(frame.size(), 8'($urandom));
    frame.insert(frame.size(), flags);
    if (flags[0]) begin
      frame.insert(frame.size(), cnt[15:8]);
      frame.insert(frame.size(), cnt[7:0]);
    end
    if (flags[3]) begin
      for (int k = 3; k >= 0; k--) frame.insert(frame.size(), cid[8*k +: 8]);
    end
    if (flags[5]) begin
      frame.insert(frame.size(), did[15:8]);
      frame.insert(frame.size(), did[7:0]);
    end
    if (flags[6]) begin
      frame.insert(frame.size(), seg[15:8]);
      frame.insert(frame.size(), seg[7:0]);
    end
    crc = 16'hFFFF;
    foreach (frame[k]) crc = crc16_step(crc, frame[k]);
    frame.insert(frame.size(), crc[15:8]);
    frame.insert(frame.size(), crc[7:0]);
    for (int k = 0; k < int'(plen); k++) frame.insert(frame.size(), 8'($urandom));
    if (!flags[2]) begin
      frame.insert(frame.size(), 8'($urandom));
      frame.insert(frame.size(), 8'($urandom));
    end
  endtask

  // Damage the frame as asked, then queue its bytes with the final-byte mark
  task automatic queue_frame(input damage_t dmg);
    int           n;
    packet_byte_t pb;
    case (dmg)
      DAMAGE_SHORT: begin
        n = $urandom_range(1, int'(MIN_PKT_LEN) - 1);
        if (frame.size() > n) frame = frame[0:n-1];
      end
      DAMAGE_START:   frame[0] ^= 8'($urandom_range(1, 255));
      DAMAGE_VERSION: frame[1] ^= 8'($urandom_range(1, 255));
      DAMAGE_HDR_LEN: frame[2] ^= 8'($urandom_range(1, 255));
      DAMAGE_PKT_LEN: begin
        if ($urandom_range(0, 1)) frame.insert(frame.size(), 8'($urandom));
        else frame.delete(frame.size() - 1);
      end
      DAMAGE_CRC: begin
        n = int'(frame[2]) - 2 + $urandom_range(0, 1);
        frame[n] ^= 8'($urandom_range(1, 255));
      end
      DAMAGE_FLIP: begin
        n = $urandom_range(0, frame.size() - 1);
        frame[n] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    foreach (frame[k]) begin
      pb.data = frame[k];
      pb.last = (k == frame.size() - 1);
      pending_bytes.insert(pending_bytes.size(), pb);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Byte driver: tracks each accepted transaction, then offers the next byte or idles
  always @(posedge clk) begin : drive_bytes
    packet_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && (steady_phase || $urandom_range(0, 99) >= 22)) begin
          item = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= item.data;
          last_byte <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted report with the oldest prediction
  always @(posedge clk) begin : check_reports
    header_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report with status %0d", status);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", want.status, status);
          check_field("app_protocol", want.proto, app_protocol);
          check_field("body_length", want.plen, body_length);
          check_field("skip_payload_crc", want.skip, skip_payload_crc);
          check_field("has_counter", want.has_cnt, has_counter);
          check_field("message_counter", want.cnt, message_counter);
          check_field("has_client_id", want.has_cid, has_client_id);
          check_field("client_id", want.cid, client_id);
          check_field("has_data_id", want.has_did, has_data_id);
          check_field("data_id", want.did, data_id);
          check_field("has_segmentation", want.has_seg, has_segmentation);
          check_field("segment_count", want.seg, segment_count);
        end
      end
      out_stall <= !steady_phase && ($urandom_range(0, 99) < 22);
    end
  end

  // Stimulus and end of run
  initial begin
    int      total_bytes;
    int      pick;
    damage_t dmg;
    logic [15:0] plen;
    clear_tracker();

    // single byte and eleven bytes: both too short
    frame.delete();
    frame.insert(frame.size(), 8'hFF);
    queue_frame(DAMAGE_NONE);
    build_frame(8'h04, 8'h00, 16'd0, 16'h0, 32'h0, 16'h0, 16'h0);
    frame = frame[0:10];
    queue_frame(DAMAGE_NONE);
    // smallest good packet: bare header, no payload, no payload CRC
    build_frame(8'h04, 8'h00, 16'd0, 16'h0, 32'h0, 16'h0, 16'h0);
    queue_frame(DAMAGE_NONE);
    // every optional field, all ones
    build_frame(8'hFF, 8'hFF, 16'd2, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(DAMAGE_NONE);
    // every optional field, zeros, payload CRC present
    build_frame(8'h69, 8'h00, 16'd1, 16'h0, 32'h0, 16'h0, 16'h0);
    queue_frame(DAMAGE_NONE);
    // each check failing in turn
    build_frame(8'h04, 8'h11, 16'd0, 16'h0, 32'h0, 16'h0, 16'h0);
    queue_frame(DAMAGE_START);
    build_frame(8'h04, 8'h22, 16'd0, 16'h0, 32'h0, 16'h0, 16'h0);
    queue_frame(DAMAGE_VERSION);
    build_frame(8'h00, 8'h33, 16'd0, 16'h0, 32'h0, 16'h0, 16'h0);
    frame[2] = 8'h00;
    queue_frame(DAMAGE_NONE);
    build_frame(8'h01, 8'h44, 16'd3, 16'h1234, 32'h0, 16'h0, 16'h0);
    queue_frame(DAMAGE_PKT_LEN);
    build_frame(8'h08, 8'h55, 16'd1, 16'h0, 32'h89AB_CDEF, 16'h0, 16'h0);
    queue_frame(DAMAGE_CRC);
    // segmentation without data id, then without counter
    build_frame(8'h45, 8'h66, 16'd0, 16'hA5A5, 32'h0, 16'h0, 16'h5A5A);
    queue_frame(DAMAGE_NONE);
    build_frame(8'h64, 8'h77, 16'd0, 16'h0, 32'h0, 16'hC3C3, 16'h3C3C);
    queue_frame(DAMAGE_NONE);

    // random frames: mostly well formed, some damaged, some pure noise
    while (pending_bytes.size() < 1550) begin
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(100, 300))
                                          : 16'($urandom_range(0, 24));
      if (pick < 10) begin
        frame.delete();
        for (int k = $urandom_range(1, 40); k > 0; k--) frame.insert(frame.size(), 8'($urandom));
        if ($urandom_range(0, 1)) begin
          frame[0] = START_BYTE;
          if (frame.size() > 1) frame[1] = VERSION_BYTE;
        end
        queue_frame(DAMAGE_NONE);
      end else begin
        build_frame(8'($urandom), 8'($urandom), plen, 16'($urandom), $urandom,
                    16'($urandom), 16'($urandom));
        dmg = (pick < 65) ? DAMAGE_NONE : damage_t'($urandom_range(1, 7));
        queue_frame(dmg);
      end
    end

    total_bytes = pending_bytes.size();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != total_bytes) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(12 * 2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/thpc_pkg.sv
rtl/core/thpc_hdr_state.sv
rtl/core/thpc_result.sv
rtl/core/transport_packet_header_checker.sv
tb/transport_packet_header_checker_tb.sv
